### sv/sle_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and codes for the sorted list engine: operation and status
// codes, request and response item layouts, default table capacity.
// ----------------------------------------------------------------------------
package sle_pkg;

   // default number of cells in the table
   localparam int CAPACITY_DEFAULT = 16;

   // operation codes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_SEARCH = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EMPTY     = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   // request item
   typedef struct packed {
      logic [1:0]         op;
      logic signed [31:0] value;
   } req_type;

   // response item
   typedef struct packed {
      logic [1:0] status;
      logic [3:0] position;
      logic [4:0] count;
   } rsp_type;

   // shift commands broadcast to every cell
   typedef struct packed {
      logic shift_up;
      logic shift_down;
   } cell_ctl_type;

endpackage
`default_nettype wire

### sv/sle_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sle_cell
// One slot of the sorted table: holds one value, compares it against the
// search key and takes the key or a neighbor's value when the row shifts.
// ----------------------------------------------------------------------------
module sle_cell (
   input  wire                      clock,
   input  wire signed [31:0]        key,
   input  wire signed [31:0]        prev_value,
   input  wire signed [31:0]        next_value,
   input  wire                      in_range,
   input  wire                      prev_lt,
   input  sle_pkg::cell_ctl_type    ctl,
   output logic signed [31:0]       value,
   output logic                     lt,
   output logic                     hit
);

   logic signed [31:0] value_ff;
   logic signed [31:0] value_in;
   logic               boundary;

   // compare against the key, only inside the filled part
   assign lt       = in_range && (value_ff < key);
   assign boundary = prev_lt && !lt;
   assign hit      = in_range && boundary && (value_ff == key);
   assign value    = value_ff;

   // insert opens a gap at the boundary, remove closes it from above
   always_comb begin
      value_in = value_ff;
      if (ctl.shift_up && !lt) begin
         value_in = boundary ? key : prev_value;
      end else if (ctl.shift_down && !lt) begin
         value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule
`default_nettype wire

### sv/sorted_list_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_list_engine
// Bounded table of signed values kept in ascending order with insert,
// remove and search operations, built as a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
//  channel   ports                        handshake
//  request   start, busy, req_data        accepted when start & !busy
//  response  rsp_valid, rsp_data          one-cycle strobe, always taken
//
//  for each item the accept edge latches the command, the next
//  edge runs the parallel compare in every cell, shifts the row and
//  registers the response, which shows for one cycle after that edge.
//  busy is high for the single compare cycle; a new item may start in the
//  cycle the response is shown. reset clears the count and the strobe;
//  the receiver cannot stall the response.
// ----------------------------------------------------------------------------
module sorted_list_engine #(
   parameter int CAPACITY = sle_pkg::CAPACITY_DEFAULT
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               start,
   output logic              busy,
   input  sle_pkg::req_type  req_data,
   output logic              rsp_valid,
   output sle_pkg::rsp_type  rsp_data
);

   localparam int CntW = $clog2(CAPACITY + 1);

   logic                  busy_ff;
   sle_pkg::req_type      cmd_ff;
   logic [CntW-1:0]       count_ff;
   logic [CntW-1:0]       count_in;
   logic                  rsp_valid_ff;
   sle_pkg::rsp_type      rsp_ff;
   sle_pkg::rsp_type      rsp_in;

   logic signed [31:0]    cell_value [CAPACITY];
   logic [CAPACITY-1:0]   cell_lt;
   logic [CAPACITY-1:0]   cell_hit;
   sle_pkg::cell_ctl_type ctl;
   logic                  found;
   logic [3:0]            hit_pos;
   logic                  full;
   logic                  empty;
   logic [CntW+4:0]       count_ext;

   // row of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [31:0] prev_value;
      logic signed [31:0] next_value;
      logic               prev_lt;
      logic               in_range;
      if (i == 0) begin : g_first
         assign prev_value = cmd_ff.value;
         assign prev_lt    = 1'b1;
      end else begin : g_mid
         assign prev_value = cell_value[i-1];
         assign prev_lt    = cell_lt[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign next_value = cell_value[i];
      end else begin : g_inner
         assign next_value = cell_value[i+1];
      end
      assign in_range = CntW'(i) < count_ff;
      sle_cell u_cell (
         .clock      (clock),
         .key        (cmd_ff.value),
         .prev_value (prev_value),
         .next_value (next_value),
         .in_range   (in_range),
         .prev_lt    (prev_lt),
         .ctl        (ctl),
         .value      (cell_value[i]),
         .lt         (cell_lt[i]),
         .hit        (cell_hit[i])
      );
   end

   // match flag and low bits of the matching cell index
   always_comb begin
      found   = |cell_hit;
      hit_pos = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         hit_pos = hit_pos | (cell_hit[i] ? 4'(i) : 4'd0);
      end
   end

   assign full  = count_ff == CntW'(CAPACITY);
   assign empty = count_ff == '0;

   // shift commands, next count and response
   always_comb begin
      ctl.shift_up   = 1'b0;
      ctl.shift_down = 1'b0;
      count_in       = count_ff;
      rsp_in.status  = sle_pkg::ST_OK;
      rsp_in.position = '0;
      case (cmd_ff.op)
         sle_pkg::OP_INSERT: begin
            if (full) begin
               rsp_in.status = sle_pkg::ST_FULL;
            end else begin
               ctl.shift_up = busy_ff;
               count_in     = count_ff + CntW'(1);
            end
         end
         sle_pkg::OP_REMOVE: begin
            if (empty) begin
               rsp_in.status = sle_pkg::ST_EMPTY;
            end else if (!found) begin
               rsp_in.status = sle_pkg::ST_NOT_FOUND;
            end else begin
               ctl.shift_down = busy_ff;
               count_in       = count_ff - CntW'(1);
            end
         end
         sle_pkg::OP_SEARCH: begin
            if (empty) begin
               rsp_in.status = sle_pkg::ST_EMPTY;
            end else if (!found) begin
               rsp_in.status = sle_pkg::ST_NOT_FOUND;
            end else begin
               rsp_in.position = hit_pos;
            end
         end
         default: begin
         end
      endcase
      count_ext    = {5'd0, count_in};
      rsp_in.count = count_ext[4:0];
   end

   // control and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= busy_ff;
         if (busy_ff) begin
            busy_ff  <= 1'b0;
            count_ff <= count_in;
         end else if (start) begin
            busy_ff <= 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         cmd_ff <= req_data;
      end
      if (busy_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

### tb/sv/sle_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_scoreboard
// Watches the request and response channels of the sorted list engine. It
// keeps its own sorted table, works out the response for every accepted
// item and compares each response strobe, field by field, with the oldest
// outstanding one.
// ----------------------------------------------------------------------------
module sle_scoreboard #(
   parameter int CAPACITY = sle_pkg::CAPACITY_DEFAULT
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               start,
   input  wire               busy,
   input  sle_pkg::req_type  req_data,
   input  wire               rsp_valid,
   input  sle_pkg::rsp_type  rsp_data,
   output int                fail_count,
   output int                pending_count,
   output int                checked_count
);
   import sle_pkg::*;

   // shadow copy of the sorted table
   logic signed [31:0] held_vals [CAPACITY];
   int                 held_count = 0;

   // responses owed by the engine, oldest first
   rsp_type            owed_rsp_q [$];
   int                 errors_seen = 0;
   int                 rsp_checked = 0;

   // run one operation on the shadow table and return the response it gives
   function automatic rsp_type apply_table_op(req_type item);
      rsp_type            res;
      logic signed [31:0] key;
      int                 idx;
      res.status   = ST_OK;
      res.position = '0;
      key          = $signed(item.value);
      // first slot holding a value not below the key
      idx = 0;
      while (idx < held_count && held_vals[idx] < key) idx++;
      case (item.op)
         OP_INSERT: begin
            if (held_count >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               for (int j = held_count; j > idx; j--) held_vals[j] = held_vals[j - 1];
               held_vals[idx] = key;
               held_count++;
            end
         end
         OP_REMOVE: begin
            if (held_count == 0) begin
               res.status = ST_EMPTY;
            end else if (idx >= held_count || held_vals[idx] != key) begin
               res.status = ST_NOT_FOUND;
            end else begin
               for (int j = idx; j + 1 < held_count; j++) held_vals[j] = held_vals[j + 1];
               held_count--;
            end
         end
         OP_SEARCH: begin
            if (held_count == 0) begin
               res.status = ST_EMPTY;
            end else if (idx >= held_count || held_vals[idx] != key) begin
               res.status = ST_NOT_FOUND;
            end else begin
               res.position = 4'(idx);
            end
         end
         default: begin
            // spare code leaves the table alone
         end
      endcase
      res.count = 5'(held_count);
      return res;
   endfunction

   // compare responses, then record newly accepted items
   always @(posedge clock) begin
      rsp_type owed;
      if (reset) begin
         held_count = 0;
         owed_rsp_q.delete();
      end else begin
         if (rsp_valid) begin
            if (owed_rsp_q.size() == 0) begin
               errors_seen++;
               if (errors_seen <= 10)
                  $display("%0t: response with none owed: status %0d position %0d count %0d",
                           $realtime, rsp_data.status, rsp_data.position, rsp_data.count);
            end else begin
               owed = owed_rsp_q.pop_front();
               rsp_checked++;
               if (rsp_data.status !== owed.status || rsp_data.position !== owed.position ||
                   rsp_data.count !== owed.count) begin
                  errors_seen++;
                  if (errors_seen <= 10)
                     $display("%0t: response %0d wrong: status %0d/%0d position %0d/%0d count %0d/%0d (expected/actual)",
                              $realtime, rsp_checked, owed.status, rsp_data.status,
                              owed.position, rsp_data.position, owed.count, rsp_data.count);
               end
            end
         end
         if (start && !busy) owed_rsp_q.push_back(apply_table_op(req_data));
      end
      fail_count    <= errors_seen;
      pending_count <= owed_rsp_q.size();
      checked_count <= rsp_checked;
   end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the sorted list engine. A directed pass covers
// empty, single entry, duplicate, extreme and full-table cases; random
// bursts then fill and drain the table with random gaps between items.
// ----------------------------------------------------------------------------
module tb_top;
   import sle_pkg::*;

   // spare operation code, no name in the package
   localparam logic [1:0] OP_SPARE     = 2'd3;
   localparam int         RANDOM_ITEMS = 1850;
   localparam int         RECENT_MAX   = 24;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    start     = 1'b0;
   req_type req_data  = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   int fail_count;
   int pending_count;
   int checked_count;
   int sent_by_op [4];

   // values inserted lately, so removes and searches hit often
   logic signed [31:0] recent_vals [$];

   always #5 clock = ~clock;

   sorted_list_engine DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   sle_scoreboard u_sle_scoreboard (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   // present one item and hold it until the engine takes it
   task automatic send_item(input logic [1:0] op, input logic signed [31:0] value);
      @(negedge clock);
      start          <= 1'b1;
      req_data.op    <= op;
      req_data.value <= value;
      do @(posedge clock); while (busy);
      sent_by_op[op]++;
      if (op == OP_INSERT) begin
         recent_vals.push_back(value);
         if (recent_vals.size() > RECENT_MAX) void'(recent_vals.pop_front());
      end
   endtask

   // drop start for a pause of the given length, with noise on the request bus
   task automatic pause_input(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         start          <= 1'b0;
         req_data.op    <= 2'($urandom);
         req_data.value <= $urandom;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   // mostly no gap, some short, a few long
   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // value for an item; known values are favored for removes and searches
   function automatic logic signed [31:0] pick_value(input bit prefer_known);
      int sel;
      sel = $urandom_range(0, 9);
      if (prefer_known && sel < 6 && recent_vals.size() > 0)
         return recent_vals[$urandom_range(0, recent_vals.size() - 1)];
      case (sel)
         0, 1, 2, 3: return 32'($urandom_range(0, 16)) - 32'sd8;
         4:          return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         5:          return 32'sh7FFF_FFFF - 32'($urandom_range(0, 3));
         6:          return 32'sh8000_0000 + 32'($urandom_range(0, 3));
         default:    return $urandom;
      endcase
   endfunction

   // directed pass: empty table, single entry, extremes, duplicates, full table
   task automatic run_directed();
      send_item(OP_SEARCH, 32'sd5);
      send_item(OP_REMOVE, 32'sd5);
      send_item(OP_INSERT, 32'sd7);
      send_item(OP_REMOVE, 32'sd7);
      send_item(OP_INSERT, 32'sh7FFF_FFFF);
      send_item(OP_INSERT, 32'sh8000_0000);
      send_item(OP_INSERT, 32'sd0);
      send_item(OP_INSERT, 32'sd0);
      send_item(OP_SEARCH, 32'sd0);
      send_item(OP_REMOVE, 32'sd5);
      send_item(OP_SEARCH, -32'sd5);
      send_item(OP_SPARE, 32'sh5A5A_A5A5);
      for (int k = 0; k < 13; k++) send_item(OP_INSERT, k * 37 - 200);
      send_item(OP_INSERT, 32'sd1);
      send_item(OP_SEARCH, 32'sh7FFF_FFFF);
   endtask

   // random bursts, each leaning toward filling, draining or a mix
   task automatic run_random();
      int         random_sent;
      int         burst_len;
      int         mode;
      int         r;
      bit         idle_on;
      logic [1:0] op;
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         burst_len = $urandom_range(10, 60);
         mode      = $urandom_range(0, 2);
         idle_on   = $urandom_range(0, 3) != 0;
         for (int n = 0; n < burst_len && random_sent < RANDOM_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            case (mode)
               0:       op = (r < 65) ? OP_INSERT : (r < 80) ? OP_REMOVE :
                             (r < 98) ? OP_SEARCH : OP_SPARE;
               1:       op = (r < 20) ? OP_INSERT : (r < 65) ? OP_REMOVE :
                             (r < 98) ? OP_SEARCH : OP_SPARE;
               default: op = (r < 35) ? OP_INSERT : (r < 65) ? OP_REMOVE :
                             (r < 98) ? OP_SEARCH : OP_SPARE;
            endcase
            send_item(op, pick_value(op != OP_INSERT));
            if (idle_on) pause_input(draw_gap());
            random_sent++;
         end
      end
   endtask

   // reset, stimulus, drain and verdict
   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      @(negedge clock);
      start <= 1'b0;
      for (int w = 0; w < 1000 && pending_count != 0; w++) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("items sent: %0d inserts, %0d removes, %0d searches, %0d spare codes",
               sent_by_op[OP_INSERT], sent_by_op[OP_REMOVE], sent_by_op[OP_SEARCH],
               sent_by_op[OP_SPARE]);
      $display("responses checked: %0d, failures: %0d, still owed: %0d",
               checked_count, fail_count, pending_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("run timed out");
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
